// ===== hw/rtl/tsc_pkg.sv =====
// Shared types and constants of the transcript structure clusterer.
package tsc_pkg;

	typedef struct packed {
		logic [7:0]  chrom_id;
		logic        strand_minus;
		logic [30:0] tx_start;
		logic [30:0] tx_end;
		logic [30:0] cds_start;
		logic [30:0] cds_end;
		logic [6:0]  exon_total;
		logic [30:0] exon_begin;
		logic [30:0] exon_finish;
		logic        last_exon;
	} item_t;

	typedef struct packed {
		logic [9:0]  cluster_index;
		logic        new_cluster;
		logic [15:0] member_count;
		logic        table_full;
	} result_t;

	typedef struct packed {
		logic a_gt_b;
		logic in_lim;
		logic below;
	} cmp_t;

	typedef struct packed {
		logic meta_re;
		logic q_re;
		logic ex_re;
	} ctrl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_META,
		ST_WIN,
		ST_SE,
		ST_MX_RD,
		ST_MX_S,
		ST_MX_E,
		ST_HIT,
		ST_MISS,
		ST_CP_RD,
		ST_CP_WR
	} state_t;

	localparam logic [1:0]  REG_JUNCTION_TOL  = 2'd0;
	localparam logic [1:0]  REG_END_TOL       = 2'd1;
	localparam logic [1:0]  REG_SEARCH_WINDOW = 2'd2;

	localparam logic [15:0] JUNCTION_TOL_RST  = 16'd10;
	localparam logic [15:0] END_TOL_RST       = 16'd100;
	localparam logic [30:0] SEARCH_WINDOW_RST = 31'd1000000;
	localparam logic [15:0] MEMBER_MAX        = 16'hFFFF;

endpackage

// ===== hw/rtl/tsc_dist_unit.sv =====
// Shared distance unit: absolute difference of two coordinates against a limit.
module tsc_dist_unit import tsc_pkg::*; (
	input  logic [30:0] a,
	input  logic [30:0] b,
	input  logic [30:0] lim,
	output cmp_t        cmp
);
	logic        gt;
	logic [30:0] d;

	always_comb begin
		gt = a > b;
		d = gt ? a - b : b - a;
		cmp.a_gt_b = gt;
		cmp.in_lim = d <= lim;
		cmp.below  = d < lim;
	end
endmodule

// ===== hw/rtl/tsc_query_buf.sv =====
// Exon buffer of the transcript being received, with its fill count.
module tsc_query_buf import tsc_pkg::*; #(
	parameter int MAX_EXONS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic                         wr_last,
	input  logic [30:0]                  wr_begin,
	input  logic [30:0]                  wr_finish,
	input  logic                         rd_en,
	input  logic [$clog2(MAX_EXONS)-1:0] rd_idx,
	output logic [30:0]                  rd_begin,
	output logic [30:0]                  rd_finish
);
	localparam int EW = $clog2(MAX_EXONS);
	localparam int NW = $clog2(MAX_EXONS + 1);

	logic [30:0]   begin_mem [MAX_EXONS];
	logic [30:0]   finish_mem [MAX_EXONS];
	logic [NW-1:0] fill_q;
	logic [NW-1:0] recv_q;
	logic [NW-1:0] fill_inc;
	logic          room;
	logic [30:0]   rd_begin_q;
	logic [30:0]   rd_finish_q;
	logic          rd_ok_q;

	assign room     = fill_q < NW'(MAX_EXONS);
	assign fill_inc = fill_q + (room ? NW'(1) : NW'(0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			recv_q <= '0;
		end else if (wr_en) begin
			if (wr_last) begin
				recv_q <= fill_inc;
				fill_q <= '0;
			end else begin
				fill_q <= fill_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && room) begin
			begin_mem[fill_q[EW-1:0]]  <= wr_begin;
			finish_mem[fill_q[EW-1:0]] <= wr_finish;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_begin_q  <= begin_mem[rd_idx];
			rd_finish_q <= finish_mem[rd_idx];
		end
	end

	// Positions past what this transcript delivered read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ok_q <= 1'b0;
		end else if (rd_en) begin
			rd_ok_q <= NW'(rd_idx) < recv_q;
		end
	end

	assign rd_begin  = rd_ok_q ? rd_begin_q : '0;
	assign rd_finish = rd_ok_q ? rd_finish_q : '0;
endmodule

// ===== hw/rtl/transcript_structure_clusterer.sv =====
// Top level of the transcript structure clusterer: sequencer, cluster tables, result register.
// Items are exons of sorted transcripts, taken on a clock edge with start high and busy low.
// An item that is not the last exon is only buffered and leaves busy low. On the last exon
// the block turns busy and walks the cluster table from the newest entry back, one shared
// distance unit doing every distance comparison in turn: a window and header check per
// candidate, then end tests for a single-exon compare or a start and end test per exon for
// a multi-exon compare, all through one read port of each table. A match ends in the hit
// state; a new cluster passes the miss state, then a read and a write state per exon copied.
// The result is shown for one cycle with done high, in the first cycle with busy low again;
// the receiver cannot hold it off. Configuration registers are written through cfg_we,
// cfg_idx and cfg_data; the user must write them only while idle, which the block does not
// enforce. Reset empties the table and the exon buffer and loads the default tolerances;
// the table memories need no clearing pass because only written entries are ever read.
module transcript_structure_clusterer import tsc_pkg::*; #(
	parameter int MAX_CLUSTERS = 1024,
	parameter int MAX_EXONS    = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  item_t       item,
	output logic        done,
	output result_t     result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [30:0] cfg_data
);
	localparam int EW  = $clog2(MAX_EXONS);
	localparam int NW  = $clog2(MAX_EXONS + 1);
	localparam int CW  = $clog2(MAX_CLUSTERS);
	localparam int UW  = $clog2(MAX_CLUSTERS + 1);
	localparam int TOT = MAX_CLUSTERS * MAX_EXONS;
	localparam int AW  = $clog2(TOT);
	localparam int BW  = $clog2(TOT + 1);

	state_t        state_q, state_d;
	ctrl_t         ctl;
	cmp_t          cmp;
	logic [30:0]   op_a, op_b, op_lim;

	logic [15:0]   jt_q, et_q;
	logic [30:0]   sw_q;

	logic [7:0]    chrom_q;
	logic          strand_q;
	logic [30:0]   ts_q, te_q, cs_q, ce_q;
	logic [NW-1:0] n_q;
	logic [UW-1:0] used_q;
	logic [BW-1:0] ubase_q;
	logic [CW-1:0] k_q;
	logic [AW-1:0] cbase_q;
	logic [EW-1:0] i_q;
	logic [1:0]    sub_q;
	logic          l_q, r_q;
	logic          done_q;
	result_t       res_q;

	logic [7:0]    chrom_mem [MAX_CLUSTERS];
	logic          strand_mem [MAX_CLUSTERS];
	logic [61:0]   bnd_mem [MAX_CLUSTERS];
	logic [61:0]   cds_mem [MAX_CLUSTERS];
	logic [NW-1:0] cnt_mem [MAX_CLUSTERS];
	logic [15:0]   members_mem [MAX_CLUSTERS];
	logic [61:0]   exon_mem [TOT];

	logic [7:0]    m_chrom;
	logic          m_strand;
	logic [61:0]   m_bnd, m_cds;
	logic [NW-1:0] m_cnt;
	logic [15:0]   m_members;
	logic [61:0]   m_exon;
	logic [30:0]   q_begin, q_finish;

	logic          accept;
	logic [NW-1:0] n_in;
	logic          last_i;
	logic          full;
	logic          meta_we, members_we, exon_we;
	logic [CW-1:0] wr_slot;
	logic [15:0]   members_wd;
	logic          se_match;
	state_t        adv;

	assign accept = start && !busy;
	assign busy   = state_q != ST_IDLE;
	assign done   = done_q;
	assign result = res_q;
	assign last_i = (NW'(i_q) + NW'(1)) == n_q;
	assign full   = used_q == UW'(MAX_CLUSTERS);
	assign adv    = (k_q == '0) ? ST_MISS : ST_META;
	assign se_match = l_q && (r_q || cmp.below);

	always_comb begin
		if (item.exon_total == 7'd0) begin
			n_in = NW'(1);
		end else if (9'(item.exon_total) > 9'(MAX_EXONS)) begin
			n_in = NW'(MAX_EXONS);
		end else begin
			n_in = NW'(item.exon_total);
		end
	end

	tsc_query_buf #(.MAX_EXONS(MAX_EXONS)) u_qbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (accept),
		.wr_last   (item.last_exon),
		.wr_begin  (item.exon_begin),
		.wr_finish (item.exon_finish),
		.rd_en     (ctl.q_re),
		.rd_idx    (i_q),
		.rd_begin  (q_begin),
		.rd_finish (q_finish)
	);

	// Operand selection for the shared distance unit.
	always_comb begin
		op_a   = ts_q;
		op_b   = m_bnd[30:0];
		op_lim = sw_q;
		case (state_q)
			ST_SE: begin
				op_lim = 31'(et_q);
				case (sub_q)
					2'd0: begin op_a = ts_q; op_b = m_bnd[61:31]; end
					2'd1: begin op_a = ts_q; op_b = m_cds[61:31]; end
					2'd2: begin op_a = te_q; op_b = m_bnd[30:0]; end
					default: begin op_a = te_q; op_b = m_cds[30:0]; end
				endcase
			end
			ST_MX_S: begin
				op_a = q_begin; op_b = m_exon[61:31]; op_lim = 31'(jt_q);
			end
			ST_MX_E: begin
				op_a = q_finish; op_b = m_exon[30:0]; op_lim = 31'(jt_q);
			end
			default: begin
				op_a = ts_q; op_b = m_bnd[30:0]; op_lim = sw_q;
			end
		endcase
	end

	tsc_dist_unit u_dist (
		.a   (op_a),
		.b   (op_b),
		.lim (op_lim),
		.cmp (cmp)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && item.last_exon) begin
					state_d = (used_q == '0) ? ST_MISS : ST_META;
				end
			end
			ST_META: state_d = ST_WIN;
			ST_WIN: begin
				if (m_chrom != chrom_q || (cmp.a_gt_b && !cmp.in_lim)) begin
					state_d = ST_MISS;
				end else if (m_strand != strand_q || m_cnt != n_q) begin
					state_d = adv;
				end else if (n_q == NW'(1)) begin
					state_d = ST_SE;
				end else begin
					state_d = ST_MX_RD;
				end
			end
			ST_SE: begin
				if (sub_q == 2'd3) begin
					state_d = se_match ? ST_HIT : adv;
				end
			end
			ST_MX_RD: state_d = ST_MX_S;
			ST_MX_S: begin
				if (i_q != '0 && !cmp.in_lim) begin
					state_d = adv;
				end else begin
					state_d = ST_MX_E;
				end
			end
			ST_MX_E: begin
				if (last_i) begin
					state_d = ST_HIT;
				end else if (!cmp.in_lim) begin
					state_d = adv;
				end else begin
					state_d = ST_MX_RD;
				end
			end
			ST_HIT: state_d = ST_IDLE;
			ST_MISS: state_d = full ? ST_IDLE : ST_CP_RD;
			ST_CP_RD: state_d = ST_CP_WR;
			ST_CP_WR: state_d = last_i ? ST_IDLE : ST_CP_RD;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl.meta_re = state_q == ST_META;
		ctl.q_re    = state_q == ST_MX_RD || state_q == ST_CP_RD;
		ctl.ex_re   = state_q == ST_MX_RD;
	end

	assign meta_we    = state_q == ST_MISS && !full;
	assign exon_we    = state_q == ST_CP_WR;
	assign members_we = state_q == ST_HIT || meta_we;
	assign wr_slot    = meta_we ? used_q[CW-1:0] : k_q;
	assign members_wd = meta_we ? 16'd1
		: ((m_members == MEMBER_MAX) ? MEMBER_MAX : m_members + 16'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			jt_q    <= JUNCTION_TOL_RST;
			et_q    <= END_TOL_RST;
			sw_q    <= SEARCH_WINDOW_RST;
			used_q  <= '0;
			ubase_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_idx)
					REG_JUNCTION_TOL:  jt_q <= cfg_data[15:0];
					REG_END_TOL:       et_q <= cfg_data[15:0];
					REG_SEARCH_WINDOW: sw_q <= cfg_data;
					default: ;
				endcase
			end
			done_q <= (state_q == ST_HIT) || (state_q == ST_MISS && full)
				|| (state_q == ST_CP_WR && last_i);
			if (state_q == ST_CP_WR && last_i) begin
				used_q  <= used_q + UW'(1);
				ubase_q <= ubase_q + BW'(MAX_EXONS);
			end
		end
	end

	// Datapath registers of the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept && item.last_exon) begin
					chrom_q  <= item.chrom_id;
					strand_q <= item.strand_minus;
					ts_q     <= item.tx_start;
					te_q     <= item.tx_end;
					cs_q     <= item.cds_start;
					ce_q     <= item.cds_end;
					n_q      <= n_in;
					k_q      <= CW'(used_q - UW'(1));
					cbase_q  <= AW'(ubase_q - BW'(MAX_EXONS));
				end
			end
			ST_WIN: begin
				i_q   <= '0;
				sub_q <= 2'd0;
				l_q   <= 1'b0;
				r_q   <= 1'b0;
			end
			ST_SE: begin
				sub_q <= sub_q + 2'd1;
				if (sub_q[1]) begin
					r_q <= r_q || cmp.below;
				end else begin
					l_q <= l_q || cmp.below;
				end
			end
			ST_MX_E: begin
				i_q <= i_q + EW'(1);
			end
			ST_HIT: begin
				res_q.cluster_index <= 10'(k_q);
				res_q.new_cluster   <= 1'b0;
				res_q.member_count  <= members_wd;
				res_q.table_full    <= 1'b0;
			end
			ST_MISS: begin
				i_q <= '0;
				if (full) begin
					res_q.cluster_index <= '0;
					res_q.new_cluster   <= 1'b0;
					res_q.member_count  <= '0;
					res_q.table_full    <= 1'b1;
				end
			end
			ST_CP_WR: begin
				i_q <= i_q + EW'(1);
				if (last_i) begin
					res_q.cluster_index <= 10'(used_q[CW-1:0]);
					res_q.new_cluster   <= 1'b1;
					res_q.member_count  <= 16'd1;
					res_q.table_full    <= 1'b0;
				end
			end
			default: ;
		endcase
		// Stepping to the next older candidate.
		if ((state_d == ST_META && state_q != ST_IDLE)) begin
			k_q     <= k_q - CW'(1);
			cbase_q <= cbase_q - AW'(MAX_EXONS);
		end
	end

	always_ff @(posedge clk) begin
		if (meta_we) begin
			chrom_mem[wr_slot]  <= chrom_q;
			strand_mem[wr_slot] <= strand_q;
			bnd_mem[wr_slot]    <= {ts_q, te_q};
			cds_mem[wr_slot]    <= {cs_q, ce_q};
			cnt_mem[wr_slot]    <= n_q;
		end
		if (ctl.meta_re) begin
			m_chrom  <= chrom_mem[k_q];
			m_strand <= strand_mem[k_q];
			m_bnd    <= bnd_mem[k_q];
			m_cds    <= cds_mem[k_q];
			m_cnt    <= cnt_mem[k_q];
		end
	end

	always_ff @(posedge clk) begin
		if (members_we) begin
			members_mem[wr_slot] <= members_wd;
		end
		if (ctl.meta_re) begin
			m_members <= members_mem[k_q];
		end
	end

	always_ff @(posedge clk) begin
		if (exon_we) begin
			exon_mem[AW'(ubase_q) + AW'(i_q)] <= {q_begin, q_finish};
		end
		if (ctl.ex_re) begin
			m_exon <= exon_mem[cbase_q + AW'(i_q)];
		end
	end

`ifndef NO_ASSERTIONS
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a preceding search");
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= UW'(MAX_CLUSTERS))
		else $error("cluster count beyond table size");
	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.table_full |-> !result.new_cluster && result.member_count == 16'd0)
		else $error("full-table result carries a cluster");
	a_new_result: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.new_cluster |-> result.member_count == 16'd1 && $past(used_q) != used_q)
		else $error("new cluster result inconsistent with table growth");
`endif
endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench of the transcript structure clusterer, with its own cluster predictor.
`timescale 1ns / 100ps

module tb_top;
	import tsc_pkg::*;

	localparam int NCLU      = 1024;
	localparam int NEX       = 64;
	localparam int WDOG_MAX  = 300000;
	localparam longint CMAX  = 64'h7FFFFFFF;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	item_t       item;
	logic        done;
	result_t     result;
	logic        cfg_we;
	logic [1:0]  cfg_idx;
	logic [30:0] cfg_data;

	transcript_structure_clusterer dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	// Predictor state: its own copy of the exon buffer, cluster table and registers.
	logic [30:0] qx_begin [NEX];
	logic [30:0] qx_end [NEX];
	int          qx_fill;
	logic [7:0]  cl_chrom [NCLU];
	logic        cl_strand [NCLU];
	logic [30:0] cl_ts [NCLU];
	logic [30:0] cl_te [NCLU];
	logic [30:0] cl_cs [NCLU];
	logic [30:0] cl_ce [NCLU];
	int          cl_nex [NCLU];
	logic [30:0] cl_xb [NCLU*NEX];
	logic [30:0] cl_xe [NCLU*NEX];
	int          cl_members [NCLU];
	int          cl_used;
	longint      junc_tol, end_tol, win;

	result_t     awaited_results [$];
	bit          use_typed;
	result_t     typed_result;
	bit          quiet;
	int          errors, n_items, n_results, n_new, n_full;
	int          wdog = 0;

	// Transcript being built, and recent transcripts kept for near repeats.
	item_t       hdr;
	logic [30:0] xb [70];
	logic [30:0] xf [70];
	item_t       tpl_hdr [8];
	logic [30:0] tpl_b [8][8];
	logic [30:0] tpl_f [8][8];
	int          tpl_n [8];
	int          tpl_cnt, tpl_wr;
	logic [7:0]  cur_chrom;
	longint      pos;

	function automatic longint absdiff(longint a, longint b);
		return (a > b) ? a - b : b - a;
	endfunction

	function automatic bit cluster_fits(int k, logic strand, int n, longint ts, longint te);
		int base;
		base = k * NEX;
		if (cl_strand[k] != strand || cl_nex[k] != n)
			return 0;
		if (n == 1) begin
			return (absdiff(ts, cl_ts[k]) < end_tol || absdiff(ts, cl_cs[k]) < end_tol) &&
			       (absdiff(te, cl_te[k]) < end_tol || absdiff(te, cl_ce[k]) < end_tol);
		end
		for (int i = 0; i < n; i++) begin
			if (i > 0 && absdiff(qx_begin[i], cl_xb[base+i]) > junc_tol)
				return 0;
			if (i + 1 < n && absdiff(qx_end[i], cl_xe[base+i]) > junc_tol)
				return 0;
		end
		return 1;
	endfunction

	task automatic cluster_step(input item_t it, output bit has, output result_t r);
		int     n, recv, c, k;
		bit     found;
		longint ts, te, cend;
		has = 0;
		r = '0;
		found = 0;
		if (qx_fill < NEX) begin
			qx_begin[qx_fill] = it.exon_begin;
			qx_end[qx_fill] = it.exon_finish;
			qx_fill++;
		end
		if (!it.last_exon)
			return;
		has = 1;
		recv = qx_fill;
		qx_fill = 0;
		n = it.exon_total;
		if (n == 0) n = 1;
		if (n > NEX) n = NEX;
		// Positions that this transcript did not fill compare as zero.
		for (int i = recv; i < NEX; i++) begin
			qx_begin[i] = '0;
			qx_end[i] = '0;
		end
		ts = it.tx_start;
		te = it.tx_end;
		c = cl_used;
		while (c > 0) begin
			k = c - 1;
			cend = cl_te[k];
			if (cl_chrom[k] != it.chrom_id) break;
			if (ts > cend && ts - cend > win) break;
			if (cluster_fits(k, it.strand_minus, n, ts, te)) begin
				found = 1;
				c = k;
				break;
			end
			c = k;
		end
		if (found) begin
			if (cl_members[c] < 65535) cl_members[c]++;
			r.cluster_index = c[9:0];
			r.member_count = cl_members[c][15:0];
		end else if (cl_used >= NCLU) begin
			r.table_full = 1'b1;
		end else begin
			c = cl_used++;
			cl_chrom[c] = it.chrom_id;
			cl_strand[c] = it.strand_minus;
			cl_ts[c] = it.tx_start;
			cl_te[c] = it.tx_end;
			cl_cs[c] = it.cds_start;
			cl_ce[c] = it.cds_end;
			cl_nex[c] = n;
			for (int i = 0; i < n; i++) begin
				cl_xb[c*NEX+i] = qx_begin[i];
				cl_xe[c*NEX+i] = qx_end[i];
			end
			cl_members[c] = 1;
			r.cluster_index = c[9:0];
			r.new_cluster = 1'b1;
			r.member_count = 16'd1;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Called at a falling edge; returns at the falling edge after the item was taken.
	task automatic send_exon(input item_t it);
		bit      has;
		result_t r;
		result_t nxt;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		n_items++;
		cluster_step(it, has, r);
		if (has) begin
			nxt = use_typed ? typed_result : r;
			awaited_results = {awaited_results, nxt};
		end
		@(negedge clk);
	endtask

	task automatic send_tx(input int nsent);
		item_t it;
		for (int k = 0; k < nsent; k++) begin
			it = hdr;
			it.exon_begin = xb[k];
			it.exon_finish = xf[k];
			it.last_exon = (k == nsent - 1);
			send_exon(it);
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input longint val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val[30:0];
		case (idx)
			REG_JUNCTION_TOL: junc_tol = val & 16'hFFFF;
			REG_END_TOL: end_tol = val & 16'hFFFF;
			default: win = val & CMAX;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Waits for every awaited result, then lets the search of a non-result item finish.
	task automatic drain();
		start <= 1'b0;
		while (awaited_results.size() > 0) @(posedge clk);
		repeat (16) @(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic new_chrom();
		cur_chrom = $urandom_range(0, 255);
		if ($urandom_range(0, 3) == 0)
			pos = CMAX - 250000 - $urandom_range(0, 50000);
		else
			pos = $urandom_range(1000, 2000000000);
		tpl_cnt = 0;
		tpl_wr = 0;
	endtask

	function automatic int jitter(longint tol, int cap);
		int span;
		span = (tol + 2 > cap) ? cap : int'(tol) + 2;
		return $urandom_range(0, 2 * span) - span;
	endfunction

	task automatic random_tx();
		int     r, k, n, nsent;
		longint p;
		r = $urandom_range(0, 99);
		if ($urandom_range(0, 29) == 0 || pos > CMAX - 300000) new_chrom();
		if (r < 45 && tpl_cnt > 0) begin
			// A near repeat of a recent transcript, boundaries moved around the tolerance.
			k = $urandom_range(0, tpl_cnt - 1);
			hdr = tpl_hdr[k];
			n = tpl_n[k];
			for (int i = 0; i < n; i++) begin
				xb[i] = 31'(longint'(tpl_b[k][i]) + jitter(junc_tol, 40));
				xf[i] = 31'(longint'(tpl_f[k][i]) + jitter(junc_tol, 40));
			end
			if (n == 1) begin
				hdr.tx_start = 31'(longint'(hdr.tx_start) + jitter(end_tol, 150));
				hdr.tx_end = 31'(longint'(hdr.tx_end) + jitter(end_tol, 150));
			end
			if ($urandom_range(0, 9) == 0) hdr.strand_minus = ~hdr.strand_minus;
			send_tx(n);
		end else if (r < 92) begin
			n = ($urandom_range(0, 49) == 0) ? NEX : $urandom_range(1, 4);
			p = pos;
			for (int i = 0; i < n; i++) begin
				xb[i] = p[30:0];
				p = p + $urandom_range(50, 500);
				xf[i] = p[30:0];
				p = p + $urandom_range(100, 2000);
			end
			hdr = '0;
			hdr.chrom_id = cur_chrom;
			hdr.strand_minus = $urandom_range(0, 1);
			hdr.tx_start = xb[0];
			hdr.tx_end = xf[n-1];
			hdr.cds_start = 31'(longint'(xb[0]) + $urandom_range(0, 300));
			hdr.cds_end = 31'(longint'(xf[n-1]) - $urandom_range(0, 300));
			hdr.exon_total = n[6:0];
			if (n <= 8) begin
				tpl_hdr[tpl_wr] = hdr;
				tpl_n[tpl_wr] = n;
				for (int i = 0; i < n; i++) begin
					tpl_b[tpl_wr][i] = xb[i];
					tpl_f[tpl_wr][i] = xf[i];
				end
				tpl_wr = (tpl_wr + 1) % 8;
				if (tpl_cnt < 8) tpl_cnt++;
			end
			send_tx(n);
			pos = pos + $urandom_range(0, 4000);
		end else begin
			// Malformed transcript: odd exon total, missing or surplus exons, wild fields.
			nsent = ($urandom_range(0, 3) == 0) ? 70 : $urandom_range(1, 3);
			hdr.chrom_id = cur_chrom;
			hdr.strand_minus = $urandom_range(0, 1);
			hdr.tx_start = pos[30:0];
			hdr.tx_end = 31'(pos + $urandom_range(0, 200000));
			hdr.cds_start = 31'($urandom);
			hdr.cds_end = 31'($urandom);
			hdr.exon_total = $urandom_range(0, 127);
			for (int i = 0; i < nsent; i++) begin
				xb[i] = ($urandom_range(0, 4) == 0) ? 31'($urandom) : 31'(pos + i * 1000);
				xf[i] = ($urandom_range(0, 4) == 0) ? 31'($urandom) : 31'(pos + i * 1000 + 400);
			end
			send_tx(nsent);
			pos = pos + $urandom_range(0, 2000);
		end
	endtask

	typedef struct {
		item_t   it;
		int      rep;
		bit      typed;
		result_t res;
	} row_t;

	function automatic row_t mk(logic [7:0] ch, logic st, longint ts, longint te, longint cs,
			longint ce, int total, longint eb, longint ef, int rep, bit typed, result_t res);
		row_t w;
		w.it = '0;
		w.it.chrom_id = ch;
		w.it.strand_minus = st;
		w.it.tx_start = ts[30:0];
		w.it.tx_end = te[30:0];
		w.it.cds_start = cs[30:0];
		w.it.cds_end = ce[30:0];
		w.it.exon_total = total[6:0];
		w.it.exon_begin = eb[30:0];
		w.it.exon_finish = ef[30:0];
		w.rep = rep;
		w.typed = typed;
		w.res = res;
		return w;
	endfunction

	row_t rows [16];

	// Result checker: every strobe is matched against the oldest awaited result.
	always @(posedge clk) begin
		result_t e;
		if (arst_n && done) begin
			n_results++;
			if (awaited_results.size() == 0) begin
				errors++;
				$display("%0t: result with nothing awaited: expected none, actual %p", $time, result);
			end else begin
				e = awaited_results.pop_front();
				if (e.table_full) n_full++;
				if (e.new_cluster) n_new++;
				if (result.cluster_index !== e.cluster_index) begin
					errors++;
					$display("%0t: cluster_index expected %0d actual %0d", $time,
						e.cluster_index, result.cluster_index);
				end
				if (result.new_cluster !== e.new_cluster) begin
					errors++;
					$display("%0t: new_cluster expected %0d actual %0d", $time,
						e.new_cluster, result.new_cluster);
				end
				if (result.member_count !== e.member_count) begin
					errors++;
					$display("%0t: member_count expected %0d actual %0d", $time,
						e.member_count, result.member_count);
				end
				if (result.table_full !== e.table_full) begin
					errors++;
					$display("%0t: table_full expected %0d actual %0d", $time,
						e.table_full, result.table_full);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			wdog <= 0;
		else
			wdog <= wdog + 1;
		if (wdog >= WDOG_MAX) begin
			$display("%0t: no item accepted for %0d cycles", $time, WDOG_MAX);
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int      ntx;
		longint  p;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_idx = REG_JUNCTION_TOL;
		cfg_data = '0;
		errors = 0;
		n_items = 0;
		n_results = 0;
		n_new = 0;
		n_full = 0;
		qx_fill = 0;
		cl_used = 0;
		junc_tol = JUNCTION_TOL_RST;
		end_tol = END_TOL_RST;
		win = SEARCH_WINDOW_RST;
		use_typed = 0;
		quiet = 0;
		tpl_cnt = 0;
		tpl_wr = 0;
		for (int i = 0; i < NEX; i++) begin
			qx_begin[i] = '0;
			qx_end[i] = '0;
		end

		rows[0]  = mk(0, 0, 100, 500, 150, 450, 1, 100, 500, 1, 1, '{10'd0, 1'b1, 16'd1, 1'b0});
		rows[1]  = mk(0, 0, 100, 500, 150, 450, 1, 100, 500, 1, 1, '{10'd0, 1'b0, 16'd2, 1'b0});
		rows[2]  = mk(0, 0, 199, 599, 150, 450, 1, 199, 599, 1, 1, '{10'd0, 1'b0, 16'd3, 1'b0});
		rows[3]  = mk(0, 0, 250, 601, 150, 450, 1, 250, 601, 1, 1, '{10'd1, 1'b1, 16'd1, 1'b0});
		rows[4]  = mk(0, 0, 1000, 3100, 1000, 3100, 2, 1000, 1100, 2, 1,
			'{10'd2, 1'b1, 16'd1, 1'b0});
		rows[5]  = mk(0, 0, 1000, 3110, 1000, 3110, 2, 1000, 1110, 2, 1,
			'{10'd2, 1'b0, 16'd2, 1'b0});
		rows[6]  = mk(0, 0, 1000, 3111, 1000, 3111, 2, 1000, 1111, 2, 1,
			'{10'd3, 1'b1, 16'd1, 1'b0});
		rows[7]  = mk(0, 1, 1000, 3100, 1000, 3100, 2, 1000, 1100, 2, 1,
			'{10'd4, 1'b1, 16'd1, 1'b0});
		rows[8]  = mk(0, 0, 100, 500, 150, 450, 0, 100, 500, 1, 0, '0);
		rows[9]  = mk(0, 0, 5000, 9000, 5000, 9000, 127, 5000, 5500, 2, 0, '0);
		rows[10] = mk(0, 0, 10000, 136500, 10000, 136500, 64, 10000, 10500, 64, 0, '0);
		rows[11] = mk(0, 0, 10000, 136500, 10000, 136500, 64, 10000, 10500, 70, 0, '0);
		rows[12] = mk(0, 1, 20000, 30000, 20000, 30000, 3, 20000, 20500, 2, 0, '0);
		rows[13] = mk(255, 1, 64'h7FFFFF00, CMAX, 0, CMAX, 1, 64'h7FFFFF00, CMAX, 1, 0, '0);
		rows[14] = mk(0, 0, 0, 0, 0, 0, 1, 0, 0, 1, 0, '0);
		rows[15] = mk(255, 1, 64'h7FFFFF00, CMAX, 0, CMAX, 1, 64'h7FFFFF00, CMAX, 1, 0, '0);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part, with the reset values of the registers.
		foreach (rows[i]) begin
			use_typed = rows[i].typed;
			typed_result = rows[i].res;
			hdr = rows[i].it;
			for (int k = 0; k < rows[i].rep; k++) begin
				p = longint'(rows[i].it.exon_begin) + k * 2000;
				xb[k] = p[30:0];
				p = longint'(rows[i].it.exon_finish) + k * 2000;
				xf[k] = p[30:0];
			end
			send_tx(rows[i].rep);
		end
		use_typed = 0;
		drain();

		// Random transcripts under several register settings, extremes included.
		new_chrom();
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_JUNCTION_TOL, 0);
					write_reg(REG_END_TOL, 0);
					write_reg(REG_SEARCH_WINDOW, 0);
				end
				1: begin
					write_reg(REG_JUNCTION_TOL, 65535);
					write_reg(REG_END_TOL, 65535);
					write_reg(REG_SEARCH_WINDOW, CMAX);
				end
				2: begin
					write_reg(REG_JUNCTION_TOL, $urandom_range(0, 65535));
					write_reg(REG_END_TOL, $urandom_range(0, 65535));
					write_reg(REG_SEARCH_WINDOW, $urandom);
				end
				3: begin
					write_reg(REG_JUNCTION_TOL, $urandom_range(1, 30));
					write_reg(REG_END_TOL, $urandom_range(1, 200));
					write_reg(REG_SEARCH_WINDOW, $urandom_range(0, 50000));
				end
				default: begin
					quiet = 1;
					write_reg(REG_JUNCTION_TOL, JUNCTION_TOL_RST);
					write_reg(REG_END_TOL, END_TOL_RST);
					write_reg(REG_SEARCH_WINDOW, SEARCH_WINDOW_RST);
				end
			endcase
			tpl_cnt = 0;
			ntx = 24 + $urandom_range(0, 8);
			for (int t = 0; t < ntx; t++) random_tx();
			drain();
		end

		$display("Covered %0d items and %0d results: %0d new clusters, %0d with the table full.",
			n_items, n_results, n_new, n_full);
		$display("Register settings ran from zero to full scale; %0d of %0d slots were used.",
			cl_used, NCLU);
		if (errors == 0 && awaited_results.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
